FILE: hdl/bko_pkg.sv
`timescale 1ns / 1ps

package bko_pkg;

   localparam int NUM_DOTS  = 5;
   localparam int REG_W     = 24;
   localparam int COORD_W   = 12;
   localparam int CSR_IDX_W = 4;

   localparam logic [15:0] BOX_COLOUR = 16'hE007;

   localparam logic [NUM_DOTS-1:0][15:0] DOT_COLOUR = {
      16'hFF07,
      16'h1FF8,
      16'hE007,
      16'hE0FF,
      16'h00F8
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OVERLAY_ENABLE    = 4'd0,
      REG_BOX_HORIZONTAL    = 4'd1,
      REG_BOX_VERTICAL      = 4'd2,
      REG_LEFT_EYE_POINT    = 4'd3,
      REG_RIGHT_EYE_POINT   = 4'd4,
      REG_NOSE_POINT        = 4'd5,
      REG_MOUTH_LEFT_POINT  = 4'd6,
      REG_MOUTH_RIGHT_POINT = 4'd7
   } bko_reg_type;

   typedef struct packed {
      logic                             enable;
      logic [REG_W-1:0]                 box_h;
      logic [REG_W-1:0]                 box_v;
      logic [NUM_DOTS-1:0][REG_W-1:0]   points;
   } bko_cfg_type;

endpackage

FILE: hdl/bko_if.sv
`timescale 1ns / 1ps

interface bko_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [15:0] pixel_in;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_in,
                   input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input pixel_in,
                 output ready);
endinterface

interface bko_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink (input valid, input pixel_out, output ready);
endinterface

interface bko_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bbox_keypoint_overlay_core.sv
`timescale 1ns / 1ps

// channel   modport  moves                           accepted when
// req_bus   sink     pixel_x, pixel_y, pixel_in      valid && ready
// rsp_bus   source   pixel_out                       valid && ready
// csr_bus   sink     index, data                     valid && ready (ready tied high)
//
// one request per clock unless rsp_bus stalls; each request passes through the input register, then the result register
// input register feeds the box and dot logic, the result register holds the pixel
// a stalled rsp_bus fills the result register, then the input register, then drops ready
// synchronous reset clears the valid flags and all configuration registers

module bbox_keypoint_overlay_core
   import bko_pkg::*;
#(
   parameter int FRAME_WIDTH   = 240,
   parameter int FRAME_HEIGHT  = 240,
   parameter int BOX_THICKNESS = 2,
   parameter int DOT_RADIUS    = 3
) (
   input  logic     clock,
   input  logic     reset,
   bko_req_if.sink  req_bus,
   bko_rsp_if.source rsp_bus,
   bko_csr_if.sink  csr_bus
);

   bko_cfg_type cfg;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_x_ff, s1_y_ff;
   logic [15:0] s1_pix_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [15:0] s2_pix_ff, s2_pix_in;
   logic        s1_adv;

   bko_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   bko_compose #(
      .FRAME_WIDTH   (FRAME_WIDTH),
      .FRAME_HEIGHT  (FRAME_HEIGHT),
      .BOX_THICKNESS (BOX_THICKNESS),
      .DOT_RADIUS    (DOT_RADIUS)
   ) u_compose (
      .cfg       (cfg),
      .pixel_x   (s1_x_ff),
      .pixel_y   (s1_y_ff),
      .pixel_in  (s1_pix_ff),
      .pixel_out (s2_pix_in)
   );

   assign s1_adv        = s1_valid_ff && (!s2_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in   = (req_bus.valid && req_bus.ready) || (s1_valid_ff && !s1_adv);
   assign s2_valid_in   = s1_adv || (s2_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid     = s2_valid_ff;
   assign rsp_bus.pixel_out = s2_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_x_ff   <= req_bus.pixel_x;
         s1_y_ff   <= req_bus.pixel_y;
         s1_pix_ff <= req_bus.pixel_in;
      end
      if (s1_adv) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_pix_ff) && $stable(s1_x_ff))
      else $error("input register changed while blocked");

   a_pass_disabled: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !cfg.enable |=> rsp_bus.valid && rsp_bus.pixel_out == $past(s1_pix_ff))
      else $error("pixel altered with overlay disabled");

endmodule

FILE: hdl/bko_csr.sv
`timescale 1ns / 1ps

module bko_csr
   import bko_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bko_csr_if.sink     csr,
   output bko_cfg_type cfg
);

   bko_cfg_type cfg_ff;
   bko_cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_OVERLAY_ENABLE:    cfg_in.enable    = csr.data[0];
            REG_BOX_HORIZONTAL:    cfg_in.box_h     = csr.data;
            REG_BOX_VERTICAL:      cfg_in.box_v     = csr.data;
            REG_LEFT_EYE_POINT:    cfg_in.points[0] = csr.data;
            REG_RIGHT_EYE_POINT:   cfg_in.points[1] = csr.data;
            REG_NOSE_POINT:        cfg_in.points[2] = csr.data;
            REG_MOUTH_LEFT_POINT:  cfg_in.points[3] = csr.data;
            REG_MOUTH_RIGHT_POINT: cfg_in.points[4] = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/bko_compose.sv
`timescale 1ns / 1ps

module bko_compose
   import bko_pkg::*;
#(
   parameter int FRAME_WIDTH   = 240,
   parameter int FRAME_HEIGHT  = 240,
   parameter int BOX_THICKNESS = 2,
   parameter int DOT_RADIUS    = 3
) (
   input  bko_cfg_type cfg,
   input  logic [7:0]  pixel_x,
   input  logic [7:0]  pixel_y,
   input  logic [15:0] pixel_in,
   output logic [15:0] pixel_out
);

   localparam int BW  = COORD_W + 2;
   localparam int DW  = COORD_W + 1;
   localparam int RW  = (DOT_RADIUS < 2) ? 1 : $clog2(DOT_RADIUS + 1);
   localparam int SQW = 2 * RW + 1;
   localparam logic [SQW-1:0] R_SQ = SQW'(DOT_RADIUS * DOT_RADIUS);

   logic                 in_frame;
   logic signed [BW-1:0] xs, ys, x0, x1, y0, y1;
   logic signed [BW-1:0] d_left, d_right, d_top, d_bottom;
   logic                 in_cols, in_rows, edge_row, edge_col, box_hit;
   logic [NUM_DOTS-1:0]  dot_hit;

   assign in_frame = ({1'b0, pixel_x} < 9'(FRAME_WIDTH)) &&
                     ({1'b0, pixel_y} < 9'(FRAME_HEIGHT));

   assign xs = $signed({{(BW-8){1'b0}}, pixel_x});
   assign ys = $signed({{(BW-8){1'b0}}, pixel_y});
   assign x0 = $signed({{2{cfg.box_h[11]}}, cfg.box_h[11:0]});
   assign x1 = $signed({{2{cfg.box_h[23]}}, cfg.box_h[23:12]});
   assign y0 = $signed({{2{cfg.box_v[11]}}, cfg.box_v[11:0]});
   assign y1 = $signed({{2{cfg.box_v[23]}}, cfg.box_v[23:12]});

   assign d_left   = xs - x0;
   assign d_right  = x1 - BW'(1) - xs;
   assign d_top    = ys - y0;
   assign d_bottom = y1 - BW'(1) - ys;

   assign in_cols  = (xs >= x0) && (xs < x1);
   assign in_rows  = (ys >= y0) && (ys < y1);
   assign edge_row = (!d_top[BW-1] && (d_top < BW'(BOX_THICKNESS))) ||
                     (!d_bottom[BW-1] && (d_bottom < BW'(BOX_THICKNESS)));
   assign edge_col = (!d_left[BW-1] && (d_left < BW'(BOX_THICKNESS))) ||
                     (!d_right[BW-1] && (d_right < BW'(BOX_THICKNESS)));
   assign box_hit  = (in_cols && edge_row) || (in_rows && edge_col);

   for (genvar i = 0; i < NUM_DOTS; i++) begin : g_dot
      logic signed [DW-1:0] cx, cy, dx, dy;
      logic        [DW-1:0] adx, ady;
      logic        [RW-1:0] nx, ny;
      logic        [SQW-1:0] dist_sq;
      logic                  near;

      assign cx  = $signed({cfg.points[i][11], cfg.points[i][11:0]});
      assign cy  = $signed({cfg.points[i][23], cfg.points[i][23:12]});
      assign dx  = $signed({{(DW-8){1'b0}}, pixel_x}) - cx;
      assign dy  = $signed({{(DW-8){1'b0}}, pixel_y}) - cy;
      assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
      assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
      assign near = (adx <= DW'(DOT_RADIUS)) && (ady <= DW'(DOT_RADIUS));
      assign nx  = adx[RW-1:0];
      assign ny  = ady[RW-1:0];
      // squares stay narrow once both offsets are within the radius
      assign dist_sq = SQW'(nx * nx) + SQW'(ny * ny);
      assign dot_hit[i] = (cfg.points[i] != '0) && near && (dist_sq <= R_SQ);
   end

   always_comb begin
      pixel_out = pixel_in;
      if (cfg.enable && in_frame) begin
         if (box_hit) begin
            pixel_out = BOX_COLOUR;
         end
         // later dots win
         for (int i = 0; i < NUM_DOTS; i++) begin
            if (dot_hit[i]) begin
               pixel_out = DOT_COLOUR[i];
            end
         end
      end
   end

endmodule
